// ----- src/mssr_pkg.sv -----
// Shared types and constants for the soft-start ramp block.
// No dependencies; compiled first.
package mssr_pkg;

    localparam int FULL_SCALE_DEF = 1000;
    localparam int LEVEL_W        = 11;
    localparam int PERIOD_W       = 16;
    localparam int CMP_W          = 18;
    localparam int PROD_W         = PERIOD_W + LEVEL_W;
    localparam int VALUE_W        = 7;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = '1;
    localparam logic [LEVEL_W-1:0]  STEP_RESET   = LEVEL_W'(10);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    localparam logic [7:0] CHAR_D    = 8'h64;
    localparam logic [7:0] CHAR_R    = 8'h72;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TENS,
        PH_UNITS
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SDIV,
        ST_MUL,
        ST_CDIV,
        ST_DONE
    } state_t;

endpackage

// ----- src/mssr_in_if.sv -----
// Input channel: timer tick or serial character, valid/ready handshake.
// Depends on nothing.
interface mssr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic       button_pressed;
    logic [7:0] serial_char;

    modport source (output valid, command, button_pressed, serial_char, input ready);
    modport sink   (input valid, command, button_pressed, serial_char, output ready);
endinterface

// ----- src/mssr_out_if.sv -----
// Result channel: parser flags, compare value and drive level.
// Depends on mssr_pkg for field widths.
interface mssr_out_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic                                acknowledged;
    logic                                compare_update;
    logic [mssr_pkg::CMP_W-1:0]          pwm_compare;
    logic [mssr_pkg::LEVEL_W-1:0]        drive_level;

    modport source (output valid, accepted, acknowledged, compare_update, pwm_compare,
                    drive_level, input ready);
    modport sink   (input valid, accepted, acknowledged, compare_update, pwm_compare,
                    drive_level, output ready);
endinterface

// ----- src/mssr_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; widths set by parameters.
module mssr_mul #(
    parameter int A_W = 16,
    parameter int B_W = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0]   a_reg;
    logic [A_W-1:0]   hi_reg, hi_next;
    logic [B_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W:0]     sum;

    // partial sum for the current multiplier bit, then shift right
    always_comb
    begin
        sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        hi_next = sum[A_W:1];
        lo_next = {sum[0], lo_reg[B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ----- src/mssr_div.sv -----
// Restoring divider, one quotient bit per cycle; shared by the ramp-step
// and compare-scaling divisions. Standalone; widths set by parameters.
module mssr_div #(
    parameter int N_W = 27,
    parameter int D_W = 11
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             q_bit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[N_W-1]};
        diff  = trial - {1'b0, d_reg};
        q_bit = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out of the top as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[D_W-1:0] : trial[D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/motor_soft_start_ramp.sv -----
// Soft-start motor ramp with serial setup parser; top level.
// Per word: accept, then the ramp-step divide when an 'r' setting needs it, then the serial
// multiply, the compare-scaling divide, and last the output register.
// Throughput: one word in flight; the next is taken only once the last has been posted.
// Reset (rst_n, async low): period 1000, max level FULL_SCALE, step 10, power 0.
// Uses mssr_pkg, mssr_in_if, mssr_out_if, mssr_mul, mssr_div.
module motor_soft_start_ramp #(
    parameter int FULL_SCALE = mssr_pkg::FULL_SCALE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mssr_in_if.sink                       item,
    mssr_out_if.source                    result,
    input  logic                          cfg_we,
    input  logic [mssr_pkg::PERIOD_W-1:0] cfg_wdata
);

    localparam int LW = mssr_pkg::LEVEL_W;
    localparam int VW = mssr_pkg::VALUE_W;
    localparam int PW = mssr_pkg::PROD_W;

    mssr_pkg::state_t state_reg, state_next;
    mssr_pkg::phase_t phase_reg, phase_next;

    logic [mssr_pkg::PERIOD_W-1:0] period_reg;
    logic          target_reg, target_next;
    logic [VW-1:0] value_reg, value_next;
    logic [LW-1:0] max_reg, max_next;
    logic [LW-1:0] step_reg, step_next;
    logic [LW-1:0] power_reg, power_next;

    logic          acc_reg, acc_next;
    logic          ack_reg, ack_next;
    logic          upd_reg, upd_next;
    logic [mssr_pkg::CMP_W-1:0] cmp_reg, cmp_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_acc_reg, out_ack_reg, out_upd_reg;
    logic [mssr_pkg::CMP_W-1:0] out_cmp_reg;
    logic [LW-1:0] out_lvl_reg;
    logic          out_load;

    logic          take;
    logic          is_digit;
    logic [3:0]    digit;
    logic [VW-1:0] units_value;
    logic [LW-1:0] value_x10;
    logic [LW:0]   ramp_sum;

    logic          mul_start, mul_done;
    logic [PW-1:0] product;
    logic          div_start, div_done;
    logic [PW-1:0] div_dividend;
    logic [LW-1:0] div_divisor;
    logic [PW-1:0] quotient;

    assign take        = item.valid && (state_reg == mssr_pkg::ST_IDLE);
    assign is_digit    = (item.serial_char >= mssr_pkg::CHAR_ZERO) &&
                         (item.serial_char <= mssr_pkg::CHAR_NINE);
    assign digit       = item.serial_char[3:0];
    assign units_value = value_reg + VW'(digit);
    assign value_x10   = {1'b0, units_value, 3'b000} + {3'b000, units_value, 1'b0};
    assign ramp_sum    = {1'b0, power_reg} + {1'b0, step_reg};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        target_next    = target_reg;
        value_next     = value_reg;
        max_next       = max_reg;
        step_next      = step_reg;
        power_next     = power_reg;
        acc_next       = acc_reg;
        ack_next       = ack_reg;
        upd_next       = upd_reg;
        cmp_next       = cmp_reg;
        item.ready     = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = product;
        div_divisor    = LW'(FULL_SCALE);
        out_load       = 1'b0;

        case (state_reg)
            mssr_pkg::ST_IDLE:
            begin
                item.ready   = 1'b1;
                div_dividend = PW'(max_reg);
                div_divisor  = value_x10;
                if (take)
                begin
                    acc_next   = 1'b0;
                    ack_next   = 1'b0;
                    upd_next   = 1'b0;
                    state_next = mssr_pkg::ST_MUL;
                    if (!item.command)
                    begin
                        if (item.button_pressed)
                        begin
                            if (power_reg < max_reg)
                            begin
                                power_next = ramp_sum[LW] ? mssr_pkg::LEVEL_MAX
                                                          : ramp_sum[LW-1:0];
                                upd_next   = 1'b1;
                            end
                            else if (power_reg > max_reg)
                            begin
                                power_next = max_reg;
                                upd_next   = 1'b1;
                            end
                        end
                        else if (power_reg != '0)
                        begin
                            power_next = '0;
                            upd_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            mssr_pkg::PH_TENS:
                            begin
                                phase_next = mssr_pkg::PH_IDLE;
                                if (is_digit)
                                begin
                                    value_next = VW'({digit, 3'b000}) + VW'({digit, 1'b0});
                                    phase_next = mssr_pkg::PH_UNITS;
                                    acc_next   = 1'b1;
                                end
                            end
                            mssr_pkg::PH_UNITS:
                            begin
                                phase_next = mssr_pkg::PH_IDLE;
                                if (is_digit)
                                begin
                                    value_next = units_value;
                                    acc_next   = 1'b1;
                                    ack_next   = 1'b1;
                                    if (!target_reg)
                                        max_next = value_x10;
                                    else if (units_value == '0)
                                        step_next = (max_reg != '0) ? max_reg : LW'(1);
                                    else
                                    begin
                                        // step = max / (value*10), serial divide
                                        div_start  = 1'b1;
                                        state_next = mssr_pkg::ST_SDIV;
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = mssr_pkg::PH_IDLE;
                                if (item.serial_char == mssr_pkg::CHAR_D ||
                                    item.serial_char == mssr_pkg::CHAR_R)
                                begin
                                    target_next = (item.serial_char == mssr_pkg::CHAR_R);
                                    value_next  = '0;
                                    phase_next  = mssr_pkg::PH_TENS;
                                    acc_next    = 1'b1;
                                end
                            end
                        endcase
                    end
                    mul_start = (state_next == mssr_pkg::ST_MUL);
                end
            end
            mssr_pkg::ST_SDIV:
            begin
                if (div_done)
                begin
                    step_next  = (quotient[LW-1:0] != '0) ? quotient[LW-1:0] : LW'(1);
                    mul_start  = 1'b1;
                    state_next = mssr_pkg::ST_MUL;
                end
            end
            mssr_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = mssr_pkg::ST_CDIV;
                end
            end
            mssr_pkg::ST_CDIV:
            begin
                if (div_done)
                begin
                    cmp_next   = quotient[mssr_pkg::CMP_W-1:0];
                    state_next = mssr_pkg::ST_DONE;
                end
            end
            mssr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = mssr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mssr_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mssr_pkg::ST_IDLE;
            phase_reg     <= mssr_pkg::PH_IDLE;
            target_reg    <= 1'b0;
            value_reg     <= '0;
            max_reg       <= LW'(FULL_SCALE);
            step_reg      <= mssr_pkg::STEP_RESET;
            power_reg     <= '0;
            period_reg    <= mssr_pkg::PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            value_reg     <= value_next;
            max_reg       <= max_next;
            step_reg      <= step_next;
            power_reg     <= power_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ack_reg <= ack_next;
        upd_reg <= upd_next;
        cmp_reg <= cmp_next;
        if (out_load)
        begin
            out_acc_reg <= acc_reg;
            out_ack_reg <= ack_reg;
            out_upd_reg <= upd_reg;
            out_cmp_reg <= cmp_reg;
            out_lvl_reg <= power_reg;
        end
    end

    // operand b taken from power_next: the tick update lands on the same edge
    mssr_mul #(
        .A_W (mssr_pkg::PERIOD_W),
        .B_W (LW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (period_reg),
        .b       (power_next),
        .done    (mul_done),
        .product (product)
    );

    mssr_div #(
        .N_W (PW),
        .D_W (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign result.valid          = out_valid_reg;
    assign result.accepted       = out_acc_reg;
    assign result.acknowledged   = out_ack_reg;
    assign result.compare_update = out_upd_reg;
    assign result.pwm_compare    = out_cmp_reg;
    assign result.drive_level    = out_lvl_reg;

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == mssr_pkg::ST_MUL)
        else $error("multiplier finished outside multiply phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mssr_pkg::ST_SDIV || state_reg == mssr_pkg::ST_CDIV))
        else $error("divider finished outside a divide phase");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0)
        else $error("ramp step dropped to zero");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mssr_pkg::ST_DONE && (!out_valid_reg || result.ready))
        |=> (result.valid && state_reg == mssr_pkg::ST_IDLE))
        else $error("finished word not posted to the output register");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for motor_soft_start_ramp: a directed table, then random ticks and
// setup strings under several PWM periods and handshake patterns, checked word by word.
// Needs mssr_pkg, mssr_in_if, mssr_out_if and the block's RTL.
module tb_top;

    localparam logic CMD_TICK        = 1'b0;
    localparam logic CMD_SERIAL      = 1'b1;
    localparam int   DRAIN_CYCLES    = 100;
    localparam int   HOLD_CYCLES     = 400;
    localparam int   WORDS_PER_PHASE = 315;
    localparam int   NUM_PHASES      = 6;

    typedef struct packed {
        logic                         acc;
        logic                         ack;
        logic                         upd;
        logic [mssr_pkg::CMP_W-1:0]   cmp;
        logic [mssr_pkg::LEVEL_W-1:0] lvl;
    } drive_word_t;

    typedef struct packed {
        logic        cmd;
        logic        btn;
        logic [7:0]  ch;
        logic        lit;
        drive_word_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mssr_pkg::PERIOD_W-1:0] cfg_wdata;

    mssr_in_if  item_ch ();
    mssr_out_if result_ch ();

    motor_soft_start_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // bench copy of the drive state
    logic [mssr_pkg::PERIOD_W-1:0] pm_period;
    mssr_pkg::phase_t              pm_phase;
    logic                          pm_tgt;
    logic [mssr_pkg::VALUE_W-1:0]  pm_value;
    logic [mssr_pkg::LEVEL_W-1:0]  pm_max;
    logic [mssr_pkg::LEVEL_W-1:0]  pm_step;
    logic [mssr_pkg::LEVEL_W-1:0]  pm_power;

    drive_word_t pending_words[$];

    int   src_idle_pct;
    int   rcv_idle_pct;
    logic stall_request;
    int   n_errors;
    int   n_sent;
    int   n_results;
    int   n_acks;
    int   n_updates;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic drive_word_t ramp_next(input logic cmd, input logic btn,
                                              input logic [7:0] ch);
        drive_word_t                  r;
        logic [mssr_pkg::LEVEL_W:0]   sum;
        logic [mssr_pkg::PROD_W-1:0]  prod;
        logic                         digit;
        int                           div;
        int                           s;
        r     = '0;
        digit = (ch >= mssr_pkg::CHAR_ZERO) && (ch <= mssr_pkg::CHAR_NINE);
        if (cmd == CMD_TICK)
        begin
            if (btn)
            begin
                if (pm_power < pm_max)
                begin
                    sum      = {1'b0, pm_power} + {1'b0, pm_step};
                    pm_power = (sum > {1'b0, mssr_pkg::LEVEL_MAX})
                               ? mssr_pkg::LEVEL_MAX : sum[mssr_pkg::LEVEL_W-1:0];
                    r.upd    = 1'b1;
                end
                else if (pm_power > pm_max)
                begin
                    pm_power = pm_max;
                    r.upd    = 1'b1;
                end
            end
            else if (pm_power != '0)
            begin
                pm_power = '0;
                r.upd    = 1'b1;
            end
        end
        else
        begin
            case (pm_phase)
                mssr_pkg::PH_TENS:
                begin
                    if (digit)
                    begin
                        pm_value = mssr_pkg::VALUE_W'(int'(ch - mssr_pkg::CHAR_ZERO) * 10);
                        pm_phase = mssr_pkg::PH_UNITS;
                        r.acc    = 1'b1;
                    end
                    else
                        pm_phase = mssr_pkg::PH_IDLE;
                end
                mssr_pkg::PH_UNITS:
                begin
                    if (digit)
                    begin
                        pm_value = mssr_pkg::VALUE_W'(int'(pm_value) +
                                                      int'(ch - mssr_pkg::CHAR_ZERO));
                        if (!pm_tgt)
                            pm_max = mssr_pkg::LEVEL_W'(int'(pm_value) * 10);
                        else
                        begin
                            div = int'(pm_value) * 10;
                            // zero rise time: one tick goes straight to the ceiling
                            if (div == 0)
                                s = (pm_max != '0) ? int'(pm_max) : 1;
                            else
                            begin
                                s = int'(pm_max) / div;
                                if (s == 0)
                                    s = 1;
                            end
                            pm_step = mssr_pkg::LEVEL_W'(s);
                        end
                        r.acc = 1'b1;
                        r.ack = 1'b1;
                    end
                    pm_phase = mssr_pkg::PH_IDLE;
                end
                default:
                begin
                    pm_phase = mssr_pkg::PH_IDLE;
                    if (ch == mssr_pkg::CHAR_D || ch == mssr_pkg::CHAR_R)
                    begin
                        pm_tgt   = (ch == mssr_pkg::CHAR_R);
                        pm_value = '0;
                        pm_phase = mssr_pkg::PH_TENS;
                        r.acc    = 1'b1;
                    end
                end
            endcase
        end
        prod  = mssr_pkg::PROD_W'(pm_period) * mssr_pkg::PROD_W'(pm_power);
        r.cmp = mssr_pkg::CMP_W'(prod / mssr_pkg::PROD_W'(mssr_pkg::FULL_SCALE_DEF));
        r.lvl = pm_power;
        return r;
    endfunction

    // Offer one word, optionally after an idle gap; predict on acceptance.
    task automatic send_word(input logic cmd, input logic btn, input logic [7:0] ch,
                             input logic lit = 1'b0, input drive_word_t want = '0);
        drive_word_t w;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        item_ch.valid          <= 1'b1;
        item_ch.command        <= cmd;
        item_ch.button_pressed <= btn;
        item_ch.serial_char    <= ch;
        do
            @(posedge clk);
        while (!item_ch.ready);
        w = ramp_next(cmd, btn, ch);
        pending_words.push_back(lit ? want : w);
        n_sent++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        drive_word_t got;
        drive_word_t exp_w;
        int          stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.accepted, result_ch.acknowledged, result_ch.compare_update,
                       result_ch.pwm_compare, result_ch.drive_level};
                n_results++;
                if (pending_words.size() == 0)
                begin
                    $error("result word with nothing pending");
                    n_errors++;
                end
                else
                begin
                    exp_w = pending_words.pop_front();
                    if (got.acc !== exp_w.acc)
                    begin
                        $error("accepted: expected %0d, got %0d", exp_w.acc, got.acc);
                        n_errors++;
                    end
                    if (got.ack !== exp_w.ack)
                    begin
                        $error("acknowledged: expected %0d, got %0d", exp_w.ack, got.ack);
                        n_errors++;
                    end
                    if (got.upd !== exp_w.upd)
                    begin
                        $error("compare_update: expected %0d, got %0d", exp_w.upd, got.upd);
                        n_errors++;
                    end
                    if (got.cmp !== exp_w.cmp)
                    begin
                        $error("pwm_compare: expected %0d, got %0d", exp_w.cmp, got.cmp);
                        n_errors++;
                    end
                    if (got.lvl !== exp_w.lvl)
                    begin
                        $error("drive_level: expected %0d, got %0d", exp_w.lvl, got.lvl);
                        n_errors++;
                    end
                    if (exp_w.ack)
                        n_acks++;
                    if (exp_w.upd)
                        n_updates++;
                end
            end
            // long hold-off: block fills and must stall its input
            if (stall_request)
            begin
                stall_left = HOLD_CYCLES;
                stall_request <= 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin : stimulus
        dir_row_t                      dir_rows [0:25];
        int                            kind;
        int                            phase;
        int                            sent;
        logic [7:0]                    c;
        logic [mssr_pkg::PERIOD_W-1:0] per;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        item_ch.valid          = 1'b0;
        item_ch.command        = CMD_TICK;
        item_ch.button_pressed = 1'b0;
        item_ch.serial_char    = '0;
        stall_request          = 1'b0;
        src_idle_pct           = 0;
        rcv_idle_pct           = 0;
        n_errors               = 0;
        n_sent                 = 0;
        n_results              = 0;
        n_acks                 = 0;
        n_updates              = 0;

        pm_period = mssr_pkg::PERIOD_RESET;
        pm_phase  = mssr_pkg::PH_IDLE;
        pm_tgt    = 1'b0;
        pm_value  = '0;
        pm_max    = mssr_pkg::LEVEL_W'(mssr_pkg::FULL_SCALE_DEF);
        pm_step   = mssr_pkg::STEP_RESET;
        pm_power  = '0;

        // cmd, button, char, literal?, {acc, ack, upd, compare, level}
        dir_rows = '{
            '{CMD_TICK,   1'b0, 8'h00,              1'b1, '{1'b0, 1'b0, 1'b0, 18'd0,  11'd0}},
            '{CMD_TICK,   1'b1, 8'hFF,              1'b1, '{1'b0, 1'b0, 1'b1, 18'd10, 11'd10}},
            '{CMD_SERIAL, 1'b1, mssr_pkg::CHAR_D,    1'b1, '{1'b1, 1'b0, 1'b0, 18'd10, 11'd10}},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_ZERO, 1'b0, '0},
            '{CMD_SERIAL, 1'b0, "5",                1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_R,    1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_ZERO, 1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_ZERO, 1'b0, '0},
            '{CMD_TICK,   1'b1, 8'h00,              1'b0, '0},
            '{CMD_TICK,   1'b1, 8'h00,              1'b0, '0},
            '{CMD_TICK,   1'b1, 8'h00,              1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_R,    1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_NINE, 1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_NINE, 1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_D,    1'b0, '0},
            '{CMD_SERIAL, 1'b0, "x",                1'b1, '{1'b0, 1'b0, 1'b0, 18'd50, 11'd50}},
            '{CMD_SERIAL, 1'b0, "5",                1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_R,    1'b0, '0},
            '{CMD_SERIAL, 1'b0, "3",                1'b0, '0},
            '{CMD_SERIAL, 1'b0, " ",                1'b0, '0},
            '{CMD_SERIAL, 1'b1, 8'hFF,              1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_D,    1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_NINE, 1'b0, '0},
            '{CMD_SERIAL, 1'b0, mssr_pkg::CHAR_NINE, 1'b0, '0},
            '{CMD_TICK,   1'b1, 8'h00,              1'b0, '0},
            '{CMD_TICK,   1'b0, 8'h00,              1'b0, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].btn, dir_rows[i].ch,
                      dir_rows[i].lit, dir_rows[i].want);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       per = '1;
                1:       per = mssr_pkg::PERIOD_W'(1);
                2:       per = '0;
                3:       per = mssr_pkg::PERIOD_W'($urandom_range(2, 65534));
                4:       per = mssr_pkg::PERIOD_W'(12345);
                default: per = mssr_pkg::PERIOD_RESET;
            endcase
            cfg_we    <= 1'b1;
            cfg_wdata <= per;
            @(posedge clk);
            cfg_we    <= 1'b0;
            pm_period  = per;

            src_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 78 : 0;
            rcv_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 21 : 0;
            if (phase == 4)
                stall_request <= 1'b1;

            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 45)
                begin
                    send_word(CMD_TICK, ($urandom_range(99) < 80), 8'($urandom));
                    sent += 1;
                end
                else if (kind < 90)
                begin
                    c = $urandom_range(1) ? mssr_pkg::CHAR_R : mssr_pkg::CHAR_D;
                    send_word(CMD_SERIAL, 1'($urandom), c);
                    if (kind < 78)
                    begin
                        send_word(CMD_SERIAL, 1'($urandom),
                                  mssr_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                        send_word(CMD_SERIAL, 1'($urandom),
                                  mssr_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                        sent += 3;
                    end
                    else
                    begin
                        // broken string: stray byte at the tens or the units digit
                        if ($urandom_range(1))
                        begin
                            send_word(CMD_SERIAL, 1'($urandom),
                                      mssr_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                            sent += 1;
                        end
                        do
                            c = 8'($urandom);
                        while (c >= mssr_pkg::CHAR_ZERO && c <= mssr_pkg::CHAR_NINE);
                        send_word(CMD_SERIAL, 1'($urandom), c);
                        sent += 2;
                    end
                end
                else
                begin
                    send_word(CMD_SERIAL, 1'($urandom), 8'($urandom));
                    sent += 1;
                end
            end
        end
        drain();

        $display("summary: %0d words sent, %0d results checked, %0d settings completed",
                 n_sent, n_results, n_acks);
        $display("summary: %0d compare changes over %0d PWM periods incl. 0, 1 and 65535",
                 n_updates, NUM_PHASES + 1);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
